FILE: sv/cdc_pkg.sv
// Types, constants and calendar helpers for the calendar date counter.
package cdc_pkg;

	localparam int YEAR_BITS = 14;
	localparam int STEP_BITS = 16;

	// Fixed field widths of the stream words.
	localparam int DAY_W   = 5;
	localparam int MONTH_W = 4;
	localparam int YEAR_W  = 14;
	localparam int COUNT_W = 16;
	localparam int ACT_W   = 2;

	localparam int IN_DATA_W  = 40;
	localparam int OUT_DATA_W = 32;

	// 1461 days move a date by exactly four years.
	localparam int CYCLE_DAYS  = 1461;
	localparam int CYCLE_YEARS = 4;

	// Remaining count register must hold both the step count and CYCLE_DAYS.
	localparam int REM_W = (STEP_BITS > 11) ? STEP_BITS : 11;
	localparam int CMP_W = (YEAR_BITS > YEAR_W) ? YEAR_BITS : YEAR_W;

	localparam logic [DAY_W-1:0]     RESET_DAY   = DAY_W'(14);
	localparam logic [MONTH_W-1:0]   RESET_MONTH = MONTH_W'(8);
	localparam logic [YEAR_BITS-1:0] RESET_YEAR  = YEAR_BITS'(1947);

	localparam logic [MONTH_W-1:0] MONTH_JAN = MONTH_W'(1);
	localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);
	localparam logic [MONTH_W-1:0] MONTH_DEC = MONTH_W'(12);

	typedef enum logic [ACT_W-1:0] {
		ACT_LOAD     = 2'd0,
		ACT_FORWARD  = 2'd1,
		ACT_BACKWARD = 2'd2,
		ACT_COMPARE  = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_STEP = 3'b010,
		ST_SPARE = 3'b100
	} state_t;

	typedef struct packed {
		logic                   is_greater;
		logic                   is_equal;
		logic                   is_less;
		logic                   date_valid;
		logic [YEAR_W-1:0]      year;
		logic [MONTH_W-1:0]     month;
		logic [DAY_W-1:0]       day;
	} result_t;

	// Length of a month; every year divisible by four is leap. Zero for a bad month.
	function automatic logic [DAY_W-1:0] days_in(input logic [MONTH_W-1:0] month,
			input logic leap);
		logic [DAY_W-1:0] len;
		case (month)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = DAY_W'(31);
			4'd4, 4'd6, 4'd9, 4'd11:                    len = DAY_W'(30);
			4'd2:                                       len = leap ? DAY_W'(29) : DAY_W'(28);
			default:                                    len = '0;
		endcase
		return len;
	endfunction

endpackage

FILE: sv/calendar_date_counter.sv
// Calendar date counter: holds a date, loads, steps by days and compares.
//
// Channel  | Direction | Handshake                     | Contents
// s_axis   | in        | s_axis_tvalid / s_axis_tready | tuser: action; tdata: date, count
// m_axis   | out       | m_axis_tvalid / m_axis_tready | tdata: held date, valid, compare
//
// Load and compare register their word at the accepting edge, one item per cycle while
// the output is not stalled. A step on a valid date with count n runs in the step state:
// one shared add/compare unit removes floor(n/1461) four-year blocks, then moves
// n mod 1461 single days, one iteration per cycle; its word is registered when the count
// is used up and the output is free, at once for an invalid date.
// Reset sets the date to day 14, month 8, year 1947, marked valid.
// The input is not ready while a step runs or while a finished word is stalled.
module calendar_date_counter (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// [4:0] in_day, [8:5] in_month, [22:9] in_year, [38:23] step_count, [39] zero
	input  logic [cdc_pkg::IN_DATA_W-1:0] s_axis_tdata,
	// [1:0] action
	input  logic [cdc_pkg::ACT_W-1:0]     s_axis_tuser,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// [4:0] out_day, [8:5] out_month, [22:9] out_year, [23] date_valid,
	// [24] is_less, [25] is_equal, [26] is_greater, [31:27] zero
	output logic [cdc_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
	import cdc_pkg::*;

	state_t                 state_q;
	logic [DAY_W-1:0]       day_q;
	logic [MONTH_W-1:0]     month_q;
	logic [YEAR_BITS-1:0]   year_q;
	logic                   valid_q;
	logic [REM_W-1:0]       rem_q;
	logic                   backward_q;
	logic                   out_valid_q;
	result_t                out_q;

	logic                   accept;
	logic                   slot_free;
	logic                   step_done;
	logic                   out_set;
	action_t                act;
	logic [DAY_W-1:0]       in_day;
	logic [MONTH_W-1:0]     in_month;
	logic [YEAR_W-1:0]      in_year;
	logic [COUNT_W-1:0]     step_count;
	logic                   load_ok;
	logic                   cmp_less;
	logic                   cmp_equal;
	logic [CMP_W-1:0]       cur_year_x;
	logic [CMP_W-1:0]       in_year_x;

	// Shared step unit outputs.
	logic                   big_step;
	logic [DAY_W-1:0]       dim_cur;
	logic [MONTH_W-1:0]     prev_month;
	logic [YEAR_BITS-1:0]   prev_year;
	logic [DAY_W-1:0]       nxt_day;
	logic [MONTH_W-1:0]     nxt_month;
	logic [YEAR_BITS-1:0]   nxt_year;
	logic [REM_W-1:0]       nxt_rem;

	assign act        = action_t'(s_axis_tuser);
	assign in_day     = s_axis_tdata[4:0];
	assign in_month   = s_axis_tdata[8:5];
	assign in_year    = s_axis_tdata[22:9];
	assign step_count = s_axis_tdata[38:23];

	assign slot_free     = !out_valid_q || m_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE) && slot_free;
	assign accept        = s_axis_tvalid && s_axis_tready;

	assign step_done = (state_q == ST_STEP) && (rem_q == '0) && slot_free;
	assign out_set   = (accept && (act == ACT_LOAD || act == ACT_COMPARE)) || step_done;

	assign load_ok = (in_month >= MONTH_JAN) && (in_month <= MONTH_DEC) &&
		(in_day != '0) && (in_day <= days_in(in_month, (in_year[1:0] == 2'b00)));

	// Compare raw fields: year first, then month, then day.
	assign cur_year_x = CMP_W'(year_q);
	assign in_year_x  = CMP_W'(in_year);
	always_comb begin
		cmp_less  = 1'b0;
		cmp_equal = 1'b0;
		if (cur_year_x != in_year_x) begin
			cmp_less = cur_year_x < in_year_x;
		end else if (month_q != in_month) begin
			cmp_less = month_q < in_month;
		end else if (day_q != in_day) begin
			cmp_less = day_q < in_day;
		end else begin
			cmp_equal = 1'b1;
		end
	end

	// One iteration: a four-year block while the count allows it, else one day.
	assign big_step   = rem_q >= REM_W'(CYCLE_DAYS);
	assign dim_cur    = days_in(month_q, (year_q[1:0] == 2'b00));
	assign prev_month = (month_q == MONTH_JAN) ? MONTH_DEC : month_q - MONTH_W'(1);
	assign prev_year  = (month_q == MONTH_JAN) ? year_q - YEAR_BITS'(1) : year_q;

	always_comb begin
		nxt_day   = day_q;
		nxt_month = month_q;
		nxt_year  = year_q;
		if (big_step) begin
			nxt_rem = rem_q - REM_W'(CYCLE_DAYS);
			if (backward_q) begin
				nxt_year = year_q - YEAR_BITS'(CYCLE_YEARS);
			end else begin
				nxt_year = year_q + YEAR_BITS'(CYCLE_YEARS);
			end
		end else begin
			nxt_rem = rem_q - REM_W'(1);
			if (backward_q) begin
				if (day_q <= DAY_W'(1)) begin
					nxt_month = prev_month;
					nxt_year  = prev_year;
					nxt_day   = days_in(prev_month, (prev_year[1:0] == 2'b00));
				end else begin
					nxt_day = day_q - DAY_W'(1);
				end
			end else begin
				if (day_q >= dim_cur) begin
					nxt_day = DAY_W'(1);
					if (month_q == MONTH_DEC) begin
						nxt_month = MONTH_JAN;
						nxt_year  = year_q + YEAR_BITS'(1);
					end else begin
						nxt_month = month_q + MONTH_W'(1);
					end
				end else begin
					nxt_day = day_q + DAY_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			day_q       <= RESET_DAY;
			month_q     <= RESET_MONTH;
			year_q      <= RESET_YEAR;
			valid_q     <= 1'b1;
			rem_q       <= '0;
			backward_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (act)
							ACT_LOAD: begin
								day_q       <= in_day;
								month_q     <= in_month;
								year_q      <= YEAR_BITS'(in_year);
								valid_q     <= load_ok;
							end
							ACT_FORWARD, ACT_BACKWARD: begin
								// An invalid date is not stepped.
								rem_q      <= valid_q ? REM_W'(STEP_BITS'(step_count)) : '0;
								backward_q <= (act == ACT_BACKWARD);
								state_q    <= ST_STEP;
							end
							default: ;
						endcase
					end
				end
				ST_STEP: begin
					if (rem_q != '0) begin
						day_q   <= nxt_day;
						month_q <= nxt_month;
						year_q  <= nxt_year;
						rem_q   <= nxt_rem;
					end else if (slot_free) begin
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// A new word takes priority over clearing the one just taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_set) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result word; loaded together with the output valid flag.
	always_ff @(posedge clk) begin
		if (accept && act == ACT_LOAD) begin
			out_q.day        <= in_day;
			out_q.month      <= in_month;
			out_q.year       <= in_year;
			out_q.date_valid <= load_ok;
			out_q.is_less    <= 1'b0;
			out_q.is_equal   <= 1'b0;
			out_q.is_greater <= 1'b0;
		end else if (accept && act == ACT_COMPARE) begin
			out_q.day        <= day_q;
			out_q.month      <= month_q;
			out_q.year       <= YEAR_W'(year_q);
			out_q.date_valid <= valid_q;
			out_q.is_less    <= cmp_less;
			out_q.is_equal   <= cmp_equal;
			out_q.is_greater <= !cmp_less && !cmp_equal;
		end else if (step_done) begin
			out_q.day        <= day_q;
			out_q.month      <= month_q;
			out_q.year       <= YEAR_W'(year_q);
			out_q.date_valid <= valid_q;
			out_q.is_less    <= 1'b0;
			out_q.is_equal   <= 1'b0;
			out_q.is_greater <= 1'b0;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_DATA_W'(out_q);

	a_month_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> (month_q >= MONTH_JAN && month_q <= MONTH_DEC))
		else $error("valid date holds a month outside 1 to 12");

	a_day_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> (day_q != '0 && day_q <= days_in(month_q, (year_q[1:0] == 2'b00))))
		else $error("valid date holds a day outside its month");

	a_invalid_no_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_STEP && !valid_q) |-> rem_q == '0)
		else $error("stepping an invalid date");

	a_rem_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_STEP && rem_q != '0) |=> rem_q < $past(rem_q))
		else $error("remaining count did not decrease");

endmodule

FILE: tb/tb_calendar_date_counter.sv
`timescale 1ns / 1ps
// Self-checking testbench for the calendar date counter: a directed table, then random words.
module tb_calendar_date_counter;
	import cdc_pkg::*;

	localparam int CYCLE_LIMIT  = 12_000_000;
	localparam int RANDOM_WORDS = 1725;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 40;

	typedef struct packed {
		action_t            act;
		logic [DAY_W-1:0]   day;
		logic [MONTH_W-1:0] month;
		logic [YEAR_W-1:0]  year;
		logic [COUNT_W-1:0] count;
		logic               typed;
		result_t            want;
	} stim_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata;
	logic [ACT_W-1:0]      s_axis_tuser;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;

	// Typed expectation travelling alongside the word on the bus.
	logic                  live_typed;
	result_t               live_want;

	// Predicted date held by the block.
	logic [DAY_W-1:0]      held_day;
	logic [MONTH_W-1:0]    held_month;
	logic [YEAR_W-1:0]     held_year;
	logic                  held_ok;

	result_t               held_date_q[$];
	stim_row_t             directed_rows[25];
	int                    fails = 0;
	int                    cycle_count = 0;
	bit                    calm = 1'b0;
	bit                    hold_req = 1'b0;

	always #1 clk = ~clk;

	calendar_date_counter dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	function automatic int month_days(input logic [MONTH_W-1:0] month,
			input logic [YEAR_W-1:0] year);
		case (month)
			2: return (year[1:0] == 2'b00) ? 29 : 28;
			4, 6, 9, 11: return 30;
			1, 3, 5, 7, 8, 10, 12: return 31;
			default: return 0;
		endcase
	endfunction

	// Applies one operation to the predicted date and returns the word it should produce.
	function automatic result_t apply_date_op(input stim_row_t row);
		result_t           res;
		int                span;
		int                left;
		logic [YEAR_W-1:0] four_yr;
		res = '0;
		case (row.act)
			ACT_LOAD: begin
				held_day   = row.day;
				held_month = row.month;
				held_year  = row.year;
				held_ok    = row.month >= 1 && row.month <= 12 && row.day >= 1
					&& int'(row.day) <= month_days(row.month, row.year);
			end
			ACT_FORWARD, ACT_BACKWARD: if (held_ok) begin
				// Whole four-year blocks only move the year; the rest is walked day by day.
				span    = row.count / CYCLE_DAYS;
				left    = row.count % CYCLE_DAYS;
				four_yr = YEAR_W'(CYCLE_YEARS * span);
				if (row.act == ACT_FORWARD) begin
					held_year = held_year + four_yr;
					repeat (left) begin
						if (int'(held_day) < month_days(held_month, held_year)) begin
							held_day = held_day + 1'b1;
						end else begin
							held_day = 1;
							if (held_month == 12) begin
								held_month = 1;
								held_year  = held_year + 1'b1;
							end else begin
								held_month = held_month + 1'b1;
							end
						end
					end
				end else begin
					held_year = held_year - four_yr;
					repeat (left) begin
						if (held_day > 1) begin
							held_day = held_day - 1'b1;
						end else begin
							if (held_month == 1) begin
								held_month = 12;
								held_year  = held_year - 1'b1;
							end else begin
								held_month = held_month - 1'b1;
							end
							held_day = DAY_W'(month_days(held_month, held_year));
						end
					end
				end
			end
			ACT_COMPARE: begin
				// Raw fields are compared even when either date is not a real one.
				if (held_year != row.year) res.is_less = held_year < row.year;
				else if (held_month != row.month) res.is_less = held_month < row.month;
				else if (held_day != row.day) res.is_less = held_day < row.day;
				else res.is_equal = 1'b1;
				res.is_greater = !res.is_less && !res.is_equal;
			end
		endcase
		res.day        = held_day;
		res.month      = held_month;
		res.year       = held_year;
		res.date_valid = held_ok;
		return res;
	endfunction

	// Mostly real dates and short steps so the rollover paths get exercised often.
	function automatic stim_row_t random_row();
		stim_row_t row;
		int        pick;
		int        len;
		row       = '0;
		row.day   = DAY_W'($urandom);
		row.month = MONTH_W'($urandom);
		row.year  = YEAR_W'($urandom);
		row.count = COUNT_W'($urandom);
		pick      = $urandom_range(99);
		if (pick < 25) begin
			row.act = ACT_LOAD;
			if ($urandom_range(99) < 85) begin
				case ($urandom_range(4))
					0: row.year = YEAR_W'($urandom_range(3));
					1: row.year = YEAR_W'($urandom_range(16383, 16380));
					default: ;
				endcase
				row.month = MONTH_W'($urandom_range(12, 1));
				len       = month_days(row.month, row.year);
				if ($urandom_range(2) == 0) row.day = DAY_W'(len);
				else row.day = DAY_W'($urandom_range(len, 1));
			end
		end else if (pick < 85) begin
			if (pick < 55) row.act = ACT_FORWARD;
			else row.act = ACT_BACKWARD;
			case ($urandom_range(19))
				0, 1: ;
				2: row.count = COUNT_W'(CYCLE_DAYS * $urandom_range(44) + $urandom_range(2) - 1);
				3, 4, 5, 6: row.count = COUNT_W'($urandom_range(3000));
				default: row.count = COUNT_W'($urandom_range(40));
			endcase
		end else begin
			row.act = ACT_COMPARE;
			if ($urandom_range(9) < 7) begin
				row.day   = held_day;
				row.month = held_month;
				row.year  = held_year;
				case ($urandom_range(9))
					0: row.day = row.day + 1'b1;
					1: row.day = row.day - 1'b1;
					2: row.month = row.month + 1'b1;
					3: row.month = row.month - 1'b1;
					4: row.year = row.year + 1'b1;
					5: row.year = row.year - 1'b1;
					default: ;
				endcase
			end
		end
		return row;
	endfunction

	task automatic offer_word(input stim_row_t row);
		while (!calm && $urandom_range(99) < 16) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= row.act;
		// Top bit of the input word is padding.
		s_axis_tdata  <= {1'b0, row.count, row.year, row.month, row.day};
		live_typed    <= row.typed;
		live_want     <= row.want;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// Predicts on every accepted input word, then checks every accepted output word.
	always @(posedge clk) begin
		stim_row_t seen;
		result_t   want;
		result_t   got;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				seen.act   = action_t'(s_axis_tuser);
				seen.day   = s_axis_tdata[4:0];
				seen.month = s_axis_tdata[8:5];
				seen.year  = s_axis_tdata[22:9];
				seen.count = s_axis_tdata[38:23];
				seen.typed = live_typed;
				seen.want  = live_want;
				want = apply_date_op(seen);
				held_date_q.push_back(seen.typed ? seen.want : want);
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got = result_t'(m_axis_tdata[26:0]);
				if (held_date_q.size() == 0) begin
					$error("unexpected word %h", m_axis_tdata);
					fails++;
				end else begin
					want = held_date_q.pop_front();
					if (got.day !== want.day) begin
						$error("out_day: expected %0d, got %0d", want.day, got.day);
						fails++;
					end
					if (got.month !== want.month) begin
						$error("out_month: expected %0d, got %0d", want.month, got.month);
						fails++;
					end
					if (got.year !== want.year) begin
						$error("out_year: expected %0d, got %0d", want.year, got.year);
						fails++;
					end
					if (got.date_valid !== want.date_valid) begin
						$error("date_valid: expected %0d, got %0d", want.date_valid,
							got.date_valid);
						fails++;
					end
					if (got.is_less !== want.is_less) begin
						$error("is_less: expected %0d, got %0d", want.is_less, got.is_less);
						fails++;
					end
					if (got.is_equal !== want.is_equal) begin
						$error("is_equal: expected %0d, got %0d", want.is_equal, got.is_equal);
						fails++;
					end
					if (got.is_greater !== want.is_greater) begin
						$error("is_greater: expected %0d, got %0d", want.is_greater,
							got.is_greater);
						fails++;
					end
				end
			end
		end
	end

	// Output side: random back-pressure plus one long hold-off that fills the block.
	initial begin
		int hold_left;
		bit hold_done;
		hold_left = 0;
		hold_done = 1'b0;
		m_axis_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= calm || ($urandom_range(99) >= 16);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= ACT_LOAD;
		live_typed    <= 1'b0;
		live_want     <= '0;
		// Typed expectations list is_greater, is_equal, is_less, valid, year, month, day.
		directed_rows = '{
			'{ACT_COMPARE, 14, 8, 1947, 0, 1, '{0, 1, 0, 1, 1947, 8, 14}},
			'{ACT_FORWARD, 0, 0, 0, 0, 1, '{0, 0, 0, 1, 1947, 8, 14}},
			'{ACT_LOAD, 31, 12, 16383, 0, 1, '{0, 0, 0, 1, 16383, 12, 31}},
			'{ACT_FORWARD, 0, 0, 0, 1, 1, '{0, 0, 0, 1, 0, 1, 1}},
			'{ACT_BACKWARD, 0, 0, 0, 1, 1, '{0, 0, 0, 1, 16383, 12, 31}},
			'{ACT_LOAD, 29, 2, 2024, 0, 1, '{0, 0, 0, 1, 2024, 2, 29}},
			'{ACT_FORWARD, 0, 0, 0, 1, 0, '0},
			'{ACT_BACKWARD, 0, 0, 0, 1, 0, '0},
			'{ACT_LOAD, 29, 2, 2023, 0, 1, '{0, 0, 0, 0, 2023, 2, 29}},
			'{ACT_FORWARD, 0, 0, 0, 5, 1, '{0, 0, 0, 0, 2023, 2, 29}},
			'{ACT_BACKWARD, 31, 15, 16383, 65535, 1, '{0, 0, 0, 0, 2023, 2, 29}},
			'{ACT_COMPARE, 29, 2, 2023, 65535, 1, '{0, 1, 0, 0, 2023, 2, 29}},
			'{ACT_LOAD, 0, 0, 0, 0, 1, '{0, 0, 0, 0, 0, 0, 0}},
			'{ACT_COMPARE, 1, 1, 0, 0, 1, '{0, 0, 1, 0, 0, 0, 0}},
			'{ACT_LOAD, 31, 15, 16383, 65535, 1, '{0, 0, 0, 0, 16383, 15, 31}},
			'{ACT_COMPARE, 0, 0, 0, 0, 1, '{1, 0, 0, 0, 16383, 15, 31}},
			'{ACT_LOAD, 31, 4, 100, 0, 1, '{0, 0, 0, 0, 100, 4, 31}},
			'{ACT_LOAD, 1, 1, 0, 0, 1, '{0, 0, 0, 1, 0, 1, 1}},
			'{ACT_BACKWARD, 0, 0, 0, 1, 0, '0},
			'{ACT_FORWARD, 0, 0, 0, 65535, 0, '0},
			'{ACT_BACKWARD, 0, 0, 0, 1461, 0, '0},
			'{ACT_FORWARD, 0, 0, 0, 1460, 0, '0},
			'{ACT_LOAD, 28, 2, 1, 0, 1, '{0, 0, 0, 1, 1, 2, 28}},
			'{ACT_FORWARD, 0, 0, 0, 1, 0, '0},
			'{ACT_COMPARE, 1, 3, 1, 0, 1, '{0, 1, 0, 1, 1, 3, 1}}
		};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed_rows[i]) offer_word(directed_rows[i]);
		for (int n = 0; n < RANDOM_WORDS; n++) begin
			calm = (n >= 700 && n < 1000);
			if (n == 300) hold_req = 1'b1;
			if (n == 1200) begin
				s_axis_tvalid <= 1'b0;
				do @(posedge clk); while (held_date_q.size() != 0);
			end
			offer_word(random_row());
		end
		s_axis_tvalid <= 1'b0;
		while (held_date_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fails == 0 && held_date_q.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

FILE: sim.f
sv/cdc_pkg.sv
sv/calendar_date_counter.sv
tb/tb_calendar_date_counter.sv
